// ===== src/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  // default channel count
  localparam int unsigned CHANNELS_DEF = 2;

  // config port
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 10;

  localparam logic [CFG_IW-1:0] REG_DEFAULT_CURRENT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SETTLE_TICKS    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FREQ_ERR_SET    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FREQ_ERR_CLEAR  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DUTY_ERR_SET    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_DUTY_ERR_CLEAR  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FILTER_COUNT    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_RETRY_LIMIT     = 3'd7;

  // current limits in amperes
  localparam logic [6:0] CUR_MIN   = 7'd6;
  localparam logic [6:0] CUR_MAX   = 7'd125;
  localparam logic [6:0] CUR_RESET = 7'd32;

  // stream widths
  localparam int unsigned IN_DW  = 40;
  localparam int unsigned OUT_DW = 32;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_ADJ      = 2'd2,
    MODE_ADJ_WAIT = 2'd3
  } mode_t;

  // filtered status codes
  typedef enum logic [1:0] {
    ST_FALSE   = 2'd0,
    ST_TRUE    = 2'd1,
    ST_UNKNOWN = 2'd2
  } stat_t;

  typedef struct packed {
    logic [6:0] default_current;
    logic [7:0] settle_ticks;
    logic [9:0] freq_err_set;
    logic [9:0] freq_err_clear;
    logic [9:0] duty_err_set;
    logic [9:0] duty_err_clear;
    logic [7:0] filter_count;
    logic [7:0] retry_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    default_current: CUR_RESET,
    settle_ticks:    8'd10,
    freq_err_set:    10'd20,
    freq_err_clear:  10'd10,
    duty_err_set:    10'd20,
    duty_err_clear:  10'd10,
    filter_count:    8'd5,
    retry_limit:     8'd3
  };

  typedef struct packed {
    logic       module_enable;
    logic       output_enable;
    logic       negative_drive;
    logic       derate_enable;
    logic [7:0] derate_percent;
    logic [15:0] measured_freq;
    logic [9:0] measured_duty;
  } item_t;

  // per-channel state word kept in the state RAM
  typedef struct packed {
    mode_t      mode_reg;
    logic [6:0] req_current;
    logic [6:0] target_current;
    logic [9:0] duty_written;
    logic [7:0] wait_count;
    logic [7:0] retry_count;
    logic       freq_raw;
    stat_t      freq_valid;
    logic [7:0] freq_filter_cnt;
    logic       duty_raw;
    stat_t      duty_valid;
    logic [7:0] duty_filter_cnt;
    logic [9:0] read_duty;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{
    mode_reg:        MODE_IDLE,
    req_current:     CUR_RESET,
    target_current:  7'd0,
    duty_written:    10'd0,
    wait_count:      8'd0,
    retry_count:     8'd0,
    freq_raw:        1'b0,
    freq_valid:      ST_UNKNOWN,
    freq_filter_cnt: 8'd0,
    duty_raw:        1'b0,
    duty_valid:      ST_UNKNOWN,
    duty_filter_cnt: 8'd0,
    read_duty:       10'd0
  };

  typedef struct packed {
    logic [9:0] pwm_duty;
    logic       pwm_update;
    logic [9:0] reported_duty;
    logic       fault_update;
    logic       fault_active;
    mode_t      mode;
  } result_t;

endpackage

// ===== src/cpd_ram.sv =====
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cpd_tick.sv =====
`timescale 1ns / 1ps

module cpd_tick (
  input  cpd_pkg::chan_rec_t rec,
  input  logic               req_dflt,
  input  logic [14:0]        derate_prod,
  input  cpd_pkg::item_t     item,
  input  cpd_pkg::cfg_t      cfg,
  output cpd_pkg::chan_rec_t rec_nxt,
  output logic               req_dflt_nxt,
  output cpd_pkg::result_t   res
);

  // hysteresis on a deviation: set above set, clear below clr, else follow the filter, or hold raw while it is unknown
  function automatic logic hyst(input logic [15:0] dev, input logic [9:0] set,
                                input logic [9:0] clr, input cpd_pkg::stat_t valid,
                                input logic raw);
    logic r;
    r = raw;
    if (dev > {6'd0, set}) begin
      r = 1'b1;
    end else if (dev < {6'd0, clr}) begin
      r = 1'b0;
    end else if (valid == cpd_pkg::ST_FALSE) begin
      r = 1'b0;
    end else if (valid == cpd_pkg::ST_TRUE) begin
      r = 1'b1;
    end
    return r;
  endfunction

  logic [30:0] quot_full;
  logic [6:0]  derate_cur;
  logic [6:0]  req_cur_n;
  logic [6:0]  req_eff;
  logic [6:0]  duty_cur;
  logic [27:0] low_full;
  logic [9:0]  duty_calc;
  logic        duty_keep;
  logic        freq_raw_n;
  logic        duty_raw_n;
  logic [15:0] freq_dev;
  logic [15:0] duty_dev;
  logic [7:0]  fcnt_inc;
  logic [7:0]  dcnt_inc;
  cpd_pkg::stat_t fval_n;
  cpd_pkg::stat_t dval_n;
  logic [7:0]  fcnt_n;
  logic [7:0]  dcnt_n;
  logic [7:0]  wait_inc;
  logic        disabled;

  // derated request: product / 100 by reciprocal, exact for products up to 12500
  assign quot_full  = {16'd0, derate_prod} * 31'd41944;
  assign derate_cur = quot_full[28:22];

  // requested current after this tick's derating update
  always_comb begin
    req_dflt_nxt = req_dflt;
    req_cur_n    = rec.req_current;
    if (item.derate_enable) begin
      if (item.derate_percent <= 8'd100) begin
        req_dflt_nxt = 1'b0;
        req_cur_n    = derate_cur;
      end
    end else begin
      req_dflt_nxt = 1'b1;
    end
  end

  assign req_eff = req_dflt_nxt ? cfg.default_current : req_cur_n;

  // current to duty, piecewise; the low segment is cur*100/6 by reciprocal
  assign duty_cur = (rec.mode_reg == cpd_pkg::MODE_IDLE) ? cfg.default_current
                                                          : rec.target_current;
  assign low_full = {21'd0, duty_cur} * 28'd1092300;

  always_comb begin
    duty_keep = 1'b0;
    duty_calc = 10'd1000;
    if (duty_cur < cpd_pkg::CUR_MIN) begin
      duty_calc = 10'd1000;
    end else if (duty_cur <= 7'd51) begin
      duty_calc = low_full[25:16];
    end else if (duty_cur <= 7'd63) begin
      duty_calc = {1'b0, duty_cur, 2'b00} + 10'd640;
    end else if (duty_cur <= cpd_pkg::CUR_MAX) begin
      duty_calc = {3'd0, duty_cur} + 10'd837;
    end else begin
      duty_keep = 1'b1;
    end
  end

  // deviations and raw errors for normal-mode checking
  assign freq_dev = (item.measured_freq >= 16'd1000) ? item.measured_freq - 16'd1000
                                                     : 16'd1000 - item.measured_freq;
  assign duty_dev = (item.measured_duty >= rec.duty_written)
                  ? {6'd0, item.measured_duty - rec.duty_written}
                  : {6'd0, rec.duty_written - item.measured_duty};

  assign freq_raw_n = (item.measured_duty == 10'd1000)
                    ? hyst(freq_dev, cfg.freq_err_set, cfg.freq_err_clear,
                           rec.freq_valid, rec.freq_raw)
                    : rec.freq_raw;
  assign duty_raw_n = hyst(duty_dev, cfg.duty_err_set, cfg.duty_err_clear,
                           rec.duty_valid, rec.duty_raw);

  // consecutive-count filters
  assign fcnt_inc = (rec.freq_filter_cnt != 8'hFF) ? rec.freq_filter_cnt + 8'd1
                                                   : rec.freq_filter_cnt;
  assign dcnt_inc = (rec.duty_filter_cnt != 8'hFF) ? rec.duty_filter_cnt + 8'd1
                                                   : rec.duty_filter_cnt;

  always_comb begin
    fval_n = rec.freq_valid;
    fcnt_n = 8'd0;
    if ({1'b0, freq_raw_n} != rec.freq_valid) begin
      fcnt_n = fcnt_inc;
      if (fcnt_inc >= cfg.filter_count) begin
        fval_n = freq_raw_n ? cpd_pkg::ST_TRUE : cpd_pkg::ST_FALSE;
        fcnt_n = 8'd0;
      end
    end
  end

  always_comb begin
    dval_n = rec.duty_valid;
    dcnt_n = 8'd0;
    if ({1'b0, duty_raw_n} != rec.duty_valid) begin
      dcnt_n = dcnt_inc;
      if (dcnt_inc >= cfg.filter_count) begin
        dval_n = duty_raw_n ? cpd_pkg::ST_TRUE : cpd_pkg::ST_FALSE;
        dcnt_n = 8'd0;
      end
    end
  end

  assign wait_inc = (rec.wait_count != 8'hFF) ? rec.wait_count + 8'd1 : rec.wait_count;
  assign disabled = !item.module_enable || !item.output_enable || item.negative_drive;

  // mode machine
  always_comb begin
    res = '0;
    // start from the stored record with this tick's request update applied
    rec_nxt.mode_reg        = rec.mode_reg;
    rec_nxt.target_current  = rec.target_current;
    rec_nxt.duty_written    = rec.duty_written;
    rec_nxt.wait_count      = rec.wait_count;
    rec_nxt.retry_count     = rec.retry_count;
    rec_nxt.freq_raw        = rec.freq_raw;
    rec_nxt.freq_valid      = rec.freq_valid;
    rec_nxt.freq_filter_cnt = rec.freq_filter_cnt;
    rec_nxt.duty_raw        = rec.duty_raw;
    rec_nxt.duty_valid      = rec.duty_valid;
    rec_nxt.duty_filter_cnt = rec.duty_filter_cnt;
    rec_nxt.read_duty       = rec.read_duty;
    rec_nxt.req_current     = req_cur_n;
    if (disabled) begin
      rec_nxt.mode_reg  = cpd_pkg::MODE_IDLE;
      res.pwm_update    = 1'b1;
      res.pwm_duty      = item.negative_drive ? 10'd0 : 10'd1000;
      rec_nxt.read_duty = res.pwm_duty;
    end else begin
      unique case (rec.mode_reg)
        cpd_pkg::MODE_IDLE: begin
          rec_nxt.wait_count     = 8'd0;
          rec_nxt.retry_count    = 8'd0;
          rec_nxt.mode_reg       = cpd_pkg::MODE_ADJ_WAIT;
          rec_nxt.target_current = cfg.default_current;
          if (!duty_keep) begin
            rec_nxt.duty_written = duty_calc;
          end
          res.pwm_update = 1'b1;
          res.pwm_duty   = rec_nxt.duty_written;
        end
        cpd_pkg::MODE_NORMAL: begin
          if (rec.target_current != req_eff) begin
            rec_nxt.target_current = req_eff;
            rec_nxt.mode_reg       = cpd_pkg::MODE_ADJ;
          end else begin
            rec_nxt.read_duty = item.measured_duty;
            if (dval_n == cpd_pkg::ST_TRUE || fval_n == cpd_pkg::ST_TRUE) begin
              if (rec.retry_count < cfg.retry_limit) begin
                rec_nxt.retry_count = rec.retry_count + 8'd1;
                rec_nxt.mode_reg    = cpd_pkg::MODE_ADJ;
              end else begin
                res.fault_update = 1'b1;
                res.fault_active = 1'b1;
                rec_nxt.mode_reg = cpd_pkg::MODE_IDLE;
              end
              // recovery clears both filters
              rec_nxt.freq_raw        = 1'b0;
              rec_nxt.freq_valid      = cpd_pkg::ST_FALSE;
              rec_nxt.freq_filter_cnt = 8'd0;
              rec_nxt.duty_raw        = 1'b0;
              rec_nxt.duty_valid      = cpd_pkg::ST_FALSE;
              rec_nxt.duty_filter_cnt = 8'd0;
            end else begin
              res.fault_update        = 1'b1;
              rec_nxt.freq_raw        = freq_raw_n;
              rec_nxt.freq_valid      = fval_n;
              rec_nxt.freq_filter_cnt = fcnt_n;
              rec_nxt.duty_raw        = duty_raw_n;
              rec_nxt.duty_valid      = dval_n;
              rec_nxt.duty_filter_cnt = dcnt_n;
            end
          end
        end
        cpd_pkg::MODE_ADJ: begin
          if (!duty_keep) begin
            rec_nxt.duty_written = duty_calc;
          end
          res.pwm_update     = 1'b1;
          res.pwm_duty       = rec_nxt.duty_written;
          rec_nxt.wait_count = 8'd0;
          rec_nxt.mode_reg   = cpd_pkg::MODE_ADJ_WAIT;
        end
        cpd_pkg::MODE_ADJ_WAIT: begin
          rec_nxt.wait_count = wait_inc;
          if (wait_inc >= cfg.settle_ticks) begin
            rec_nxt.mode_reg = cpd_pkg::MODE_NORMAL;
          end
        end
        default: begin
          rec_nxt.mode_reg = rec.mode_reg;
        end
      endcase
    end
    res.reported_duty = rec_nxt.read_duty;
    res.mode          = rec_nxt.mode_reg;
  end

endmodule

// ===== src/cp_pwm_duty_controller.sv =====
`timescale 1ns / 1ps

// Control-pilot PWM duty controller, one control tick per input request.
// Input stream: in_tuser selects the charger channel, in_tdata carries the
// enable flags, the derating percent and the measured frequency and duty.
// Output stream: one result per request with the duty to drive, the update
// strobes, the read-back duty and the channel's new mode.
// Configuration: cfg_we writes register cfg_index with cfg_wdata;
// write only while no request is in flight. A default-current write also resets
// every channel's requested current to the new default.
// A request passes the stage 1 and output registers; the result is held until
// taken. Throughput is one request per cycle while results are taken, also
// back to back on the same channel: the per-channel state RAM is read at
// acceptance and written as the request leaves stage 1, and the record just
// written is forwarded to a following request on that channel.
// Reset puts every channel into idle through per-entry valid bits, so requests
// are taken from the first cycle after reset. When the receiver stalls, the
// output register holds, the pipeline freezes and in_tready drops.

module cp_pwm_duty_controller #(
  parameter int unsigned CHANNELS = cpd_pkg::CHANNELS_DEF,
  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] module_enable, [1] output_enable, [2] negative_drive, [3] derate_enable,
  // [11:4] derate_percent, [27:12] measured_freq, [37:28] measured_duty
  input  logic [cpd_pkg::IN_DW-1:0]   in_tdata,
  // [0] channel
  input  logic                        in_tuser,
  // results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [9:0] pwm_duty, [10] pwm_update, [20:11] reported_duty, [21] fault_update,
  // [22] fault_active, [24:23] mode
  output logic [cpd_pkg::OUT_DW-1:0]  out_tdata,
  // configuration
  input  logic                        cfg_we,
  input  logic [cpd_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [cpd_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int unsigned RW = $bits(cpd_pkg::chan_rec_t);

  cpd_pkg::cfg_t      cfg_r;
  logic [6:0]         cur_clamp;
  logic [CHANNELS-1:0] ent_valid_r;
  logic [CHANNELS-1:0] req_dflt_r;

  logic               advance;
  logic               in_acc;
  logic [AW-1:0]      in_addr;
  cpd_pkg::item_t     in_item;

  logic               s1_v_r;
  logic               s1_ch_r;
  logic [AW-1:0]      s1_addr_r;
  cpd_pkg::item_t     s1_item_r;
  logic [14:0]        s1_prod_r;
  logic               fwd_hit_r;
  cpd_pkg::chan_rec_t wr_rec_r;

  logic               s1_ok;
  logic               s1_we;
  logic [RW-1:0]      ram_rdata;
  cpd_pkg::chan_rec_t cur_rec;
  logic               cur_dflt;
  cpd_pkg::chan_rec_t new_rec;
  logic               new_dflt;
  cpd_pkg::result_t   tick_res;

  logic               out_v_r;
  cpd_pkg::result_t   out_res_r;

  // handshake: the pipeline moves unless a held result is not taken
  assign advance   = !out_v_r || out_tready;
  assign in_tready = advance;
  assign in_acc    = in_tvalid && advance;
  assign in_addr   = AW'(in_tuser);

  // unpack tdata, lowest field first on the bus
  assign in_item   = {in_tdata[0], in_tdata[1], in_tdata[2], in_tdata[3],
                      in_tdata[11:4], in_tdata[27:12], in_tdata[37:28]};

  // clamp of the default-current write
  always_comb begin
    cur_clamp = cfg_wdata[6:0];
    if (cur_clamp < cpd_pkg::CUR_MIN) begin
      cur_clamp = cpd_pkg::CUR_MIN;
    end else if (cur_clamp > cpd_pkg::CUR_MAX) begin
      cur_clamp = cpd_pkg::CUR_MAX;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cpd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpd_pkg::REG_DEFAULT_CURRENT: cfg_r.default_current <= cur_clamp;
        cpd_pkg::REG_SETTLE_TICKS:    cfg_r.settle_ticks    <= cfg_wdata[7:0];
        cpd_pkg::REG_FREQ_ERR_SET:    cfg_r.freq_err_set    <= cfg_wdata;
        cpd_pkg::REG_FREQ_ERR_CLEAR:  cfg_r.freq_err_clear  <= cfg_wdata;
        cpd_pkg::REG_DUTY_ERR_SET:    cfg_r.duty_err_set    <= cfg_wdata;
        cpd_pkg::REG_DUTY_ERR_CLEAR:  cfg_r.duty_err_clear  <= cfg_wdata;
        cpd_pkg::REG_FILTER_COUNT:    cfg_r.filter_count    <= cfg_wdata[7:0];
        cpd_pkg::REG_RETRY_LIMIT:     cfg_r.retry_limit     <= cfg_wdata[7:0];
        default:                      cfg_r                 <= cfg_r;
      endcase
    end
  end

  // stage 1: request captured while the state RAM is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (advance) begin
      s1_v_r    <= in_tvalid;
      fwd_hit_r <= s1_we && (s1_addr_r == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r   <= in_tuser;
      s1_addr_r <= in_addr;
      s1_item_r <= in_item;
      s1_prod_r <= 15'(cfg_r.default_current * in_item.derate_percent);
    end
  end

  cpd_ram #(
    .WIDTH (RW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_addr_r),
    .wdata (new_rec),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // state select: forwarded write, stored entry, or reset value
  assign s1_ok = ({31'd0, s1_ch_r} < 32'(CHANNELS));
  assign s1_we = s1_v_r && advance && s1_ok;

  always_comb begin
    cur_rec  = cpd_pkg::REC_RESET;
    cur_dflt = 1'b1;
    if (s1_ok) begin
      cur_dflt = req_dflt_r[s1_addr_r];
      if (fwd_hit_r) begin
        cur_rec = wr_rec_r;
      end else if (ent_valid_r[s1_addr_r]) begin
        cur_rec = cpd_pkg::chan_rec_t'(ram_rdata);
      end
    end
  end

  cpd_tick u_tick (
    .rec          (cur_rec),
    .req_dflt     (cur_dflt),
    .derate_prod  (s1_prod_r),
    .item         (s1_item_r),
    .cfg          (cfg_r),
    .rec_nxt      (new_rec),
    .req_dflt_nxt (new_dflt),
    .res          (tick_res)
  );

  // per-entry valid bits and default-request flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      req_dflt_r  <= '1;
    end else begin
      if (s1_we) begin
        ent_valid_r[s1_addr_r] <= 1'b1;
        req_dflt_r[s1_addr_r]  <= new_dflt;
      end
      if (cfg_we && cfg_index == cpd_pkg::REG_DEFAULT_CURRENT) begin
        req_dflt_r <= '1;
      end
    end
  end

  // copy of the last record written, for a request that read the RAM meanwhile
  always_ff @(posedge clk) begin
    if (s1_we) begin
      wr_rec_r <= new_rec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= s1_ok ? tick_res : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0,
                       out_res_r.mode,
                       out_res_r.fault_active,
                       out_res_r.fault_update,
                       out_res_r.reported_duty,
                       out_res_r.pwm_update,
                       out_res_r.pwm_duty};

endmodule

// ===== tb/tb_cp_pwm_duty_controller.sv =====
`timescale 1ns / 1ps

module tb_cp_pwm_duty_controller;
  import cpd_pkg::*;

  localparam int unsigned FULL_DUTY = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // [0] module_enable, [1] output_enable, [2] negative_drive, [3] derate_enable,
  // [11:4] derate_percent, [27:12] measured_freq, [37:28] measured_duty
  logic [IN_DW-1:0]     in_tdata = '0;
  // [0] channel
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [9:0] pwm_duty, [10] pwm_update, [20:11] reported_duty, [21] fault_update,
  // [22] fault_active, [24:23] mode
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  cp_pwm_duty_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the block's registers and per-channel state
  cfg_t      pilot_cfg;
  chan_rec_t pilot_chan [2];
  result_t   pilot_results [$];

  // derating plan per channel for the random traffic
  logic       plan_den [2];
  logic [7:0] plan_pct [2];

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 87;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned pwm_writes = 0;
  int unsigned reg_writes = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // duty in per mille for a target current; above the top of the rule it keeps
  function automatic logic [9:0] duty_for_current(logic [6:0] cur, logic [9:0] keep);
    int unsigned a;
    a = cur;
    if (a < CUR_MIN) return 10'(FULL_DUTY);
    else if (a <= 51) return 10'((a * 100) / 6);
    else if (a <= 63) return 10'((a * 100) / 25 + 640);
    else if (a <= CUR_MAX) return 10'(a - 63 + 900);
    return keep;
  endfunction

  // raw error flag with a hysteresis band
  task automatic hyst_step(input int unsigned dev, input int unsigned set_lvl,
                           input int unsigned clr_lvl, input stat_t valid,
                           inout logic raw);
    if (dev > set_lvl) raw = 1'b1;
    else if (dev < clr_lvl) raw = 1'b0;
    else if (valid == ST_FALSE) raw = 1'b0;
    else if (valid == ST_TRUE) raw = 1'b1;
  endtask

  // consecutive-count filter on a raw flag
  task automatic filter_step(input logic raw, inout stat_t valid, inout logic [7:0] cnt);
    if ({1'b0, raw} != valid) begin
      if (cnt < 8'd255) cnt = cnt + 8'd1;
      if (cnt >= pilot_cfg.filter_count) begin
        valid = stat_t'({1'b0, raw});
        cnt = '0;
      end
    end else begin
      cnt = '0;
    end
  endtask

  // one control tick of one channel: updates the mirror, returns the result
  task automatic run_pilot_tick(input logic ch, input item_t it, output result_t r);
    chan_rec_t   c;
    int unsigned dev;
    c = pilot_chan[ch];
    r = '0;
    if (it.derate_enable) begin
      if (it.derate_percent <= 100)
        c.req_current = 7'((int'(pilot_cfg.default_current) * int'(it.derate_percent)) / 100);
    end else begin
      c.req_current = pilot_cfg.default_current;
    end

    if (!it.module_enable || !it.output_enable || it.negative_drive) begin
      c.mode_reg = MODE_IDLE;
      r.pwm_update = 1'b1;
      r.pwm_duty = it.negative_drive ? 10'd0 : 10'(FULL_DUTY);
      c.read_duty = r.pwm_duty;
    end else begin
      case (c.mode_reg)
        MODE_IDLE: begin
          c.wait_count = '0;
          c.mode_reg = MODE_ADJ_WAIT;
          c.retry_count = '0;
          c.target_current = pilot_cfg.default_current;
          c.duty_written = duty_for_current(c.target_current, c.duty_written);
          r.pwm_update = 1'b1;
          r.pwm_duty = c.duty_written;
        end
        MODE_NORMAL: begin
          if (c.target_current != c.req_current) begin
            c.target_current = c.req_current;
            c.mode_reg = MODE_ADJ;
          end else begin
            c.read_duty = it.measured_duty;
            // frequency is only meaningful at full duty
            if (it.measured_duty == FULL_DUTY) begin
              dev = (it.measured_freq >= FULL_DUTY) ? it.measured_freq - FULL_DUTY
                                                     : FULL_DUTY - it.measured_freq;
              hyst_step(dev, pilot_cfg.freq_err_set, pilot_cfg.freq_err_clear,
                        c.freq_valid, c.freq_raw);
            end
            filter_step(c.freq_raw, c.freq_valid, c.freq_filter_cnt);
            dev = (it.measured_duty >= c.duty_written) ? it.measured_duty - c.duty_written
                                                       : c.duty_written - it.measured_duty;
            hyst_step(dev, pilot_cfg.duty_err_set, pilot_cfg.duty_err_clear,
                      c.duty_valid, c.duty_raw);
            filter_step(c.duty_raw, c.duty_valid, c.duty_filter_cnt);
            if (c.duty_valid == ST_TRUE || c.freq_valid == ST_TRUE) begin
              if (c.retry_count < pilot_cfg.retry_limit) begin
                c.retry_count = c.retry_count + 8'd1;
                c.mode_reg = MODE_ADJ;
              end else begin
                r.fault_update = 1'b1;
                r.fault_active = 1'b1;
                c.mode_reg = MODE_IDLE;
              end
              c.freq_raw = 1'b0;
              c.freq_valid = ST_FALSE;
              c.freq_filter_cnt = '0;
              c.duty_raw = 1'b0;
              c.duty_valid = ST_FALSE;
              c.duty_filter_cnt = '0;
            end else begin
              r.fault_update = 1'b1;
              r.fault_active = 1'b0;
            end
          end
        end
        MODE_ADJ: begin
          c.duty_written = duty_for_current(c.target_current, c.duty_written);
          r.pwm_update = 1'b1;
          r.pwm_duty = c.duty_written;
          c.wait_count = '0;
          c.mode_reg = MODE_ADJ_WAIT;
        end
        default: begin
          if (c.wait_count < 8'd255) c.wait_count = c.wait_count + 8'd1;
          if (c.wait_count >= pilot_cfg.settle_ticks) c.mode_reg = MODE_NORMAL;
        end
      endcase
    end
    r.reported_duty = c.read_duty;
    r.mode = c.mode_reg;
    pilot_chan[ch] = c;
  endtask

  // offer one request, predict it once accepted
  task automatic send_tick(input logic ch, input item_t it);
    result_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= ch;
    in_tdata <= {2'b00, it.measured_duty, it.measured_freq, it.derate_percent,
                 it.derate_enable, it.negative_drive, it.output_enable, it.module_enable};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_pilot_tick(ch, it, due);
    pilot_results.push_back(due);
    ticks_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pilot_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    logic [6:0] amps;
    drain_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_DEFAULT_CURRENT: begin
        amps = val[6:0];
        if (amps < CUR_MIN) amps = CUR_MIN;
        if (amps > CUR_MAX) amps = CUR_MAX;
        pilot_cfg.default_current = amps;
        pilot_chan[0].req_current = amps;
        pilot_chan[1].req_current = amps;
      end
      REG_SETTLE_TICKS:   pilot_cfg.settle_ticks = val[7:0];
      REG_FREQ_ERR_SET:   pilot_cfg.freq_err_set = val;
      REG_FREQ_ERR_CLEAR: pilot_cfg.freq_err_clear = val;
      REG_DUTY_ERR_SET:   pilot_cfg.duty_err_set = val;
      REG_DUTY_ERR_CLEAR: pilot_cfg.duty_err_clear = val;
      REG_FILTER_COUNT:   pilot_cfg.filter_count = val[7:0];
      default:            pilot_cfg.retry_limit = val[7:0];
    endcase
  endtask

  function automatic item_t tick_of(logic men, logic oen, logic neg, logic den,
                                    logic [7:0] pct, logic [15:0] freq, logic [9:0] mduty);
    item_t it;
    it.module_enable = men;
    it.output_enable = oen;
    it.negative_drive = neg;
    it.derate_enable = den;
    it.derate_percent = pct;
    it.measured_freq = freq;
    it.measured_duty = mduty;
    return it;
  endfunction

  // mostly enabled ticks with a steady derating and readings near the
  // written duty and 1 kHz, so the channels get through to normal checking
  task automatic make_tick(output logic ch, output item_t it);
    int unsigned sel, span, centre, lo, hi;
    ch = 1'($urandom_range(1));
    if ($urandom_range(99) < 4) begin
      plan_den[ch] = 1'($urandom_range(1));
      sel = $urandom_range(99);
      if (sel < 70) plan_pct[ch] = 8'($urandom_range(100));
      else if (sel < 85) plan_pct[ch] = 8'($urandom_range(20));
      else plan_pct[ch] = 8'($urandom_range(255, 101));
    end
    it = tick_of(1'b1, 1'b1, 1'b0, plan_den[ch], plan_pct[ch], 16'd1000, 10'd0);
    if ($urandom_range(99) < 8) begin
      it.module_enable = 1'($urandom_range(1));
      it.output_enable = 1'($urandom_range(1));
      it.negative_drive = 1'($urandom_range(1));
    end
    if ($urandom_range(99) < 3) it.derate_percent = 8'($urandom_range(255));

    centre = pilot_chan[ch].duty_written;
    span = pilot_cfg.duty_err_set + 4;
    sel = $urandom_range(99);
    if (sel < 25) begin
      it.measured_duty = 10'(centre);
    end else if (sel < 65) begin
      lo = (centre > span) ? centre - span : 0;
      hi = (centre + span > FULL_DUTY) ? FULL_DUTY : centre + span;
      it.measured_duty = 10'($urandom_range(hi, lo));
    end else if (sel < 80) begin
      it.measured_duty = 10'(FULL_DUTY);
    end else begin
      it.measured_duty = 10'($urandom_range(FULL_DUTY));
    end

    span = pilot_cfg.freq_err_set + 4;
    if ($urandom_range(99) < 70) begin
      lo = (span < FULL_DUTY) ? FULL_DUTY - span : 0;
      it.measured_freq = 16'($urandom_range(FULL_DUTY + span, lo));
    end else begin
      it.measured_freq = 16'($urandom_range(65535));
    end
  endtask

  // moderate random settings, now and then the whole range
  task automatic randomize_regs();
    int unsigned fset, dset;
    fset = $urandom_range(60, 5);
    dset = $urandom_range(60, 5);
    write_reg(REG_DEFAULT_CURRENT, 10'($urandom_range(1023)));
    write_reg(REG_SETTLE_TICKS, 10'($urandom_range(6, 1)));
    write_reg(REG_FREQ_ERR_SET, 10'(fset));
    write_reg(REG_FREQ_ERR_CLEAR, 10'($urandom_range(fset + 5)));
    write_reg(REG_DUTY_ERR_SET, 10'(dset));
    write_reg(REG_DUTY_ERR_CLEAR, 10'($urandom_range(dset + 5)));
    write_reg(REG_FILTER_COUNT, 10'($urandom_range(4, 1)));
    write_reg(REG_RETRY_LIMIT, 10'($urandom_range(3)));
    if ($urandom_range(99) < 15) begin
      write_reg(REG_DUTY_ERR_SET, 10'($urandom_range(1000)));
      write_reg(REG_FREQ_ERR_CLEAR, 10'($urandom_range(1000)));
    end
  endtask

  // disabled, negative drive, settle of zero, derating edges, retry then fault
  task automatic test_directed();
    write_reg(REG_SETTLE_TICKS, 10'd0);
    write_reg(REG_FILTER_COUNT, 10'd1);
    write_reg(REG_RETRY_LIMIT, 10'd1);
    send_tick(1'b0, tick_of(1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 10'd0));
    send_tick(1'b1, tick_of(1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 16'd65535, 10'd1000));
    send_tick(1'b0, tick_of(1'b1, 1'b0, 1'b0, 1'b0, 8'd255, 16'd1000, 10'd0));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 16'd1000, 10'd533));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 16'd1000, 10'd533));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 16'd1000, 10'd533));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd101, 16'd1000, 10'd533));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd100, 16'd1000, 10'd533));
    // derate to zero amps: target under the minimum gives full duty
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd533));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd1000));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd1000));
    // frequency far off at full duty: one retry
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd65535, 10'd1000));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd1000));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd1000));
    // duty far off with retries used up: fault
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd0, 10'd0));
    send_tick(1'b0, tick_of(1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 16'd1000, 10'd1000));
    send_tick(1'b1, tick_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd50, 16'd1000, 10'd533));
  endtask

  // register extremes and the corners of the current-to-duty rule
  task automatic test_register_extremes();
    logic       ch;
    item_t      it;
    logic [6:0] corner [4];
    corner = '{7'd51, 7'd52, 7'd63, 7'd64};
    write_reg(REG_DEFAULT_CURRENT, 10'h3FF);
    write_reg(REG_SETTLE_TICKS, 10'd255);
    write_reg(REG_FREQ_ERR_SET, 10'd0);
    write_reg(REG_FREQ_ERR_CLEAR, 10'd0);
    write_reg(REG_DUTY_ERR_SET, 10'd1000);
    write_reg(REG_DUTY_ERR_CLEAR, 10'd1000);
    write_reg(REG_FILTER_COUNT, 10'd255);
    write_reg(REG_RETRY_LIMIT, 10'd255);
    repeat (60) begin
      make_tick(ch, it);
      send_tick(ch, it);
    end
    write_reg(REG_DEFAULT_CURRENT, 10'd0);
    write_reg(REG_SETTLE_TICKS, 10'd1);
    write_reg(REG_FREQ_ERR_SET, 10'd1000);
    write_reg(REG_DUTY_ERR_SET, 10'd0);
    write_reg(REG_DUTY_ERR_CLEAR, 10'd0);
    write_reg(REG_FILTER_COUNT, 10'd1);
    write_reg(REG_RETRY_LIMIT, 10'd0);
    repeat (80) begin
      make_tick(ch, it);
      send_tick(ch, it);
    end
    foreach (corner[k]) begin
      write_reg(REG_DEFAULT_CURRENT, 10'(corner[k]));
      send_tick(1'(k), tick_of(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd1000, 10'd0));
      send_tick(1'(k), tick_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 16'd1000, 10'd0));
    end
  endtask

  // random traffic under one idling setting, settings changed now and then
  task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle,
                                     input int unsigned n);
    logic  ch;
    item_t it;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 140 == 0) randomize_regs();
      make_tick(ch, it);
      send_tick(ch, it);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    logic  ch;
    item_t it;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_block();
    hold_left = 80;
    repeat (40) begin
      make_tick(ch, it);
      send_tick(ch, it);
    end
  endtask

  // receiver side: random stalls or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    errors++;
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pwm_duty = out_tdata[9:0];
      got.pwm_update = out_tdata[10];
      got.reported_duty = out_tdata[20:11];
      got.fault_update = out_tdata[21];
      got.fault_active = out_tdata[22];
      got.mode = mode_t'(out_tdata[24:23]);
      results_seen++;
      if (got.pwm_update === 1'b1) pwm_writes++;
      if (got.fault_update === 1'b1 && got.fault_active === 1'b1) faults_seen++;
      if (pilot_results.size() == 0) begin
        $display("%0t: result with none outstanding, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = pilot_results.pop_front();
        if (got.pwm_duty !== want.pwm_duty)
          flag_field("pwm_duty", want.pwm_duty, got.pwm_duty);
        if (got.pwm_update !== want.pwm_update)
          flag_field("pwm_update", want.pwm_update, got.pwm_update);
        if (got.reported_duty !== want.reported_duty)
          flag_field("reported_duty", want.reported_duty, got.reported_duty);
        if (got.fault_update !== want.fault_update)
          flag_field("fault_update", want.fault_update, got.fault_update);
        if (got.fault_active !== want.fault_active)
          flag_field("fault_active", want.fault_active, got.fault_active);
        if (got.mode !== want.mode)
          flag_field("mode", want.mode, got.mode);
      end
    end
  end

  initial begin
    pilot_cfg = CFG_RESET;
    pilot_chan[0] = REC_RESET;
    pilot_chan[1] = REC_RESET;
    plan_den = '{1'b0, 1'b1};
    plan_pct = '{8'd100, 8'd60};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_extremes();
    test_random_traffic(16, 87, 560);
    test_random_traffic(87, 16, 560);
    test_backpressure();
    test_random_traffic(0, 0, 560);

    drain_block();
    repeat (8) @(posedge clk);
    if (pilot_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pilot_results.size());
      errors++;
    end
    $display("Covered %0d control ticks on both channels across %0d register writes",
             ticks_sent, reg_writes);
    $display("Checked %0d results: %0d PWM writes, %0d faults raised",
             results_seen, pwm_writes, faults_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("%0t: run limit reached", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cpd_pkg.sv
src/cpd_ram.sv
src/cpd_tick.sv
src/cp_pwm_duty_controller.sv
tb/tb_cp_pwm_duty_controller.sv
